// ----- rtl/core/prq_pkg.sv -----
// ----------------------------------------------------------------------------
// prq_pkg: shared types and constants of the priority run queue scheduler
// Field widths, item kinds, register map and the control/status bundles
// that join the sequencer to the datapath.
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int KIND_W     = 2;
    localparam int TID_W      = 6;
    localparam int PRIO_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_WAKE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SELECT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BLOCK  = 2'd2;

    // register index taken from the word address bit
    localparam logic REG_ENABLED = 1'b0;

    typedef struct packed {
        logic             nil;
        logic [TID_W-1:0] id;
    } link_t;

    typedef struct packed {
        logic load_item;
        logic block;
        logic requeue;
        logic ap_wr;
        logic ap_nil;
        logic go_idle;
        logic pop_commit;
        logic res_load;
    } prq_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] in_kind;
        logic              in_enq;
        logic              enabled;
        logic              run_live;
        logic              keep;
        logic              pend_empty;
        logic              out_free;
    } prq_status_t;

endpackage

// ----- rtl/core/prq_if.sv -----
// ----------------------------------------------------------------------------
// prq_if: request and response channels
// Valid/ready channels carrying one request word and one response word.
// ----------------------------------------------------------------------------
interface prq_req_if;
    import prq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [TID_W-1:0]         thread_id;
    logic signed [PRIO_W-1:0] priority_req;
    logic                     suspended;
    logic                     force_switch;

    modport source (
        output valid, kind, thread_id, priority_req, suspended, force_switch,
        input  ready
    );
    modport sink (
        input  valid, kind, thread_id, priority_req, suspended, force_switch,
        output ready
    );
endinterface

interface prq_rsp_if;
    import prq_pkg::*;

    logic             valid;
    logic             ready;
    logic             switched;
    logic [TID_W-1:0] selected_thread;
    logic             idle;
    logic             requeued;
    logic             queued;

    modport source (
        output valid, switched, selected_thread, idle, requeued, queued,
        input  ready
    );
    modport sink (
        input  valid, switched, selected_thread, idle, requeued, queued,
        output ready
    );
endinterface

// ----- rtl/core/prq_ctrl.sv -----
// ----------------------------------------------------------------------------
// prq_ctrl: scheduler sequencer
// One-hot state machine stepping wake, select and block words through the
// table reads and writes of the datapath.
// ----------------------------------------------------------------------------
module prq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  prq_pkg::prq_status_t status,
    output prq_pkg::prq_cmd_t    cmd
);
    import prq_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SEL_LVL = 9'b000000010,
        S_AP_RD   = 9'b000000100,
        S_AP_WR   = 9'b000001000,
        S_AP_NIL  = 9'b000010000,
        S_POP     = 9'b000100000,
        S_POP_H   = 9'b001000000,
        S_POP_N   = 9'b010000000,
        S_RESP    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   ap_sel_reg, ap_sel_next;

    always_comb
    begin
        state_next  = state_reg;
        ap_sel_next = ap_sel_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    ap_sel_next   = 1'b0;
                    state_next    = S_RESP;
                    case (status.in_kind)
                        KIND_WAKE:
                        begin
                            if (status.in_enq)
                            begin
                                state_next = S_AP_RD;
                            end
                        end
                        KIND_SELECT:
                        begin
                            if (status.enabled && status.run_live)
                            begin
                                state_next = S_SEL_LVL;
                            end
                            else if (status.enabled)
                            begin
                                state_next = S_POP;
                            end
                        end
                        KIND_BLOCK:
                        begin
                            cmd.block = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SEL_LVL:
            begin
                if (status.keep)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.requeue = 1'b1;
                    ap_sel_next = 1'b1;
                    state_next  = S_AP_RD;
                end
            end
            S_AP_RD:
            begin
                state_next = S_AP_WR;
            end
            S_AP_WR:
            begin
                cmd.ap_wr  = 1'b1;
                state_next = S_AP_NIL;
            end
            S_AP_NIL:
            begin
                cmd.ap_nil = 1'b1;
                state_next = ap_sel_reg ? S_POP : S_RESP;
            end
            S_POP:
            begin
                if (status.pend_empty)
                begin
                    cmd.go_idle = 1'b1;
                    state_next  = S_RESP;
                end
                else
                begin
                    state_next = S_POP_H;
                end
            end
            S_POP_H:
            begin
                state_next = S_POP_N;
            end
            S_POP_N:
            begin
                cmd.pop_commit = 1'b1;
                state_next     = S_RESP;
            end
            S_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ap_sel_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ap_sel_reg <= ap_sel_next;
        end
    end

endmodule

// ----- rtl/core/prq_dp.sv -----
// ----------------------------------------------------------------------------
// prq_dp: scheduler datapath
// Pending bitmap, running slot, per-level head/tail tables, link and level
// tables, first-pending encoder and the response register.
// ----------------------------------------------------------------------------
module prq_dp #(
    parameter int MAX_THREADS     = 64,
    parameter int PRIORITY_LEVELS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [prq_pkg::KIND_W-1:0]     kind,
    input  logic [prq_pkg::TID_W-1:0]      thread_id,
    input  logic signed [prq_pkg::PRIO_W-1:0] priority_req,
    input  logic                           suspended,
    input  logic                           force_switch,
    input  logic                           enabled,
    input  prq_pkg::prq_cmd_t              cmd,
    output prq_pkg::prq_status_t           status,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           out_switched,
    output logic [prq_pkg::TID_W-1:0]      out_selected,
    output logic                           out_idle,
    output logic                           out_requeued,
    output logic                           out_queued
);
    import prq_pkg::*;

    localparam int TIDX_W = $clog2(MAX_THREADS);
    localparam int LVL_W  = $clog2(PRIORITY_LEVELS);

    logic [LVL_W-1:0] tl_mem   [MAX_THREADS];
    link_t            link_mem [MAX_THREADS];
    logic [TID_W-1:0] head_mem [PRIORITY_LEVELS];
    logic [TID_W-1:0] tail_mem [PRIORITY_LEVELS];

    logic [LVL_W-1:0] tl_rd_reg;
    link_t            link_rd_reg;
    logic [TID_W-1:0] head_rd_reg;
    logic [TID_W-1:0] tail_rd_reg;

    logic [PRIORITY_LEVELS-1:0] pending_reg, pending_next;
    logic [TID_W-1:0]           run_thr_reg, run_thr_next;
    logic                       run_present_reg, run_present_next;
    logic                       run_active_reg, run_active_next;
    logic                       out_valid_reg, out_valid_next;

    logic             force_reg;
    logic [TID_W-1:0] ap_thr_reg;
    logic [LVL_W-1:0] ap_lvl_reg;
    logic             res_switched_reg, res_idle_reg, res_requeued_reg, res_queued_reg;
    logic [TID_W-1:0] res_sel_reg;
    logic             out_switched_reg, out_idle_reg, out_requeued_reg, out_queued_reg;
    logic [TID_W-1:0] out_sel_reg;

    logic                       tid_ok;
    logic                       in_enq;
    logic [LVL_W-1:0]           lvl_in;
    logic [PRIORITY_LEVELS-1:0] iso;
    logic [LVL_W-1:0]           fp;
    logic                       pend_empty;
    logic                       ap_pend;
    logic                       head_we;
    logic [LVL_W-1:0]           head_wa;
    logic [TID_W-1:0]           head_wd;
    logic                       link_we;
    logic [TIDX_W-1:0]          link_wa;
    link_t                      link_wd;

    assign tid_ok = 32'(thread_id) < MAX_THREADS;
    assign in_enq = tid_ok && !suspended;

    always_comb
    begin
        if (priority_req[PRIO_W-1])
        begin
            lvl_in = '0;
        end
        else if ($unsigned(priority_req) > PRIO_W'(PRIORITY_LEVELS - 1))
        begin
            lvl_in = LVL_W'(PRIORITY_LEVELS - 1);
        end
        else
        begin
            lvl_in = LVL_W'($unsigned(priority_req));
        end
    end

    // lowest set bit, then OR-encode its position
    assign iso = pending_reg & (~pending_reg + 1'b1);

    always_comb
    begin
        fp = '0;
        for (int b = 0; b < LVL_W; b++)
        begin
            for (int i = 0; i < PRIORITY_LEVELS; i++)
            begin
                if (((i >> b) & 1) == 1)
                begin
                    fp[b] = fp[b] | iso[i];
                end
            end
        end
    end

    assign pend_empty = (pending_reg == '0);
    assign ap_pend    = pending_reg[ap_lvl_reg];

    assign status.in_kind    = kind;
    assign status.in_enq     = in_enq;
    assign status.enabled    = enabled;
    assign status.run_live   = run_present_reg && run_active_reg;
    assign status.keep       = !force_reg && (pend_empty || (tl_rd_reg <= fp));
    assign status.pend_empty = pend_empty;
    assign status.out_free   = !out_valid_reg || out_ready;

    // table write ports
    always_comb
    begin
        head_we = 1'b0;
        head_wa = ap_lvl_reg;
        head_wd = ap_thr_reg;
        if (cmd.ap_wr && !ap_pend)
        begin
            head_we = 1'b1;
        end
        else if (cmd.pop_commit && !link_rd_reg.nil)
        begin
            head_we = 1'b1;
            head_wa = fp;
            head_wd = link_rd_reg.id;
        end
    end

    always_comb
    begin
        link_we = 1'b0;
        link_wa = TIDX_W'(tail_rd_reg);
        link_wd = '{nil: 1'b0, id: ap_thr_reg};
        if (cmd.ap_wr && ap_pend)
        begin
            link_we = 1'b1;
        end
        else if (cmd.ap_nil)
        begin
            link_we = 1'b1;
            link_wa = TIDX_W'(ap_thr_reg);
            link_wd = '{nil: 1'b1, id: '0};
        end
    end

    always_ff @(posedge clk)
    begin
        tl_rd_reg <= tl_mem[TIDX_W'(run_thr_reg)];
        if (cmd.load_item && kind == KIND_WAKE && tid_ok)
        begin
            tl_mem[TIDX_W'(thread_id)] <= lvl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_rd_reg <= tail_mem[ap_lvl_reg];
        if (cmd.ap_wr)
        begin
            tail_mem[ap_lvl_reg] <= ap_thr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        head_rd_reg <= head_mem[fp];
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        link_rd_reg <= link_mem[TIDX_W'(head_rd_reg)];
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
    end

    always_comb
    begin
        pending_next     = pending_reg;
        run_thr_next     = run_thr_reg;
        run_present_next = run_present_reg;
        run_active_next  = run_active_reg;
        out_valid_next   = out_valid_reg;
        if (cmd.ap_wr)
        begin
            pending_next[ap_lvl_reg] = 1'b1;
        end
        if (cmd.pop_commit && link_rd_reg.nil)
        begin
            pending_next[fp] = 1'b0;
        end
        if (cmd.block || cmd.requeue)
        begin
            run_active_next = 1'b0;
        end
        if (cmd.go_idle)
        begin
            run_thr_next     = '0;
            run_present_next = 1'b0;
            run_active_next  = 1'b0;
        end
        if (cmd.pop_commit)
        begin
            run_thr_next     = head_rd_reg;
            run_present_next = 1'b1;
            run_active_next  = 1'b1;
        end
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg     <= '0;
            run_thr_reg     <= '0;
            run_present_reg <= 1'b0;
            run_active_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            pending_reg     <= pending_next;
            run_thr_reg     <= run_thr_next;
            run_present_reg <= run_present_next;
            run_active_reg  <= run_active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            force_reg        <= force_switch;
            ap_thr_reg       <= thread_id;
            ap_lvl_reg       <= lvl_in;
            res_switched_reg <= 1'b0;
            res_sel_reg      <= '0;
            res_idle_reg     <= 1'b0;
            res_requeued_reg <= 1'b0;
            res_queued_reg   <= (kind == KIND_WAKE) && in_enq;
        end
        if (cmd.requeue)
        begin
            ap_thr_reg       <= run_thr_reg;
            ap_lvl_reg       <= tl_rd_reg;
            res_requeued_reg <= 1'b1;
        end
        if (cmd.go_idle)
        begin
            res_idle_reg <= 1'b1;
        end
        if (cmd.pop_commit)
        begin
            res_switched_reg <= 1'b1;
            res_sel_reg      <= head_rd_reg;
        end
        if (cmd.res_load)
        begin
            out_switched_reg <= res_switched_reg;
            out_sel_reg      <= res_sel_reg;
            out_idle_reg     <= res_idle_reg;
            out_requeued_reg <= res_requeued_reg;
            out_queued_reg   <= res_queued_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_switched = out_switched_reg;
    assign out_selected = out_sel_reg;
    assign out_idle     = out_idle_reg;
    assign out_requeued = out_requeued_reg;
    assign out_queued   = out_queued_reg;

    a_pop_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_commit |-> !pend_empty)
        else $error("pop with empty bitmap");

    a_idle_clears_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.go_idle |=> !run_present_reg && !run_active_reg)
        else $error("idle did not clear running slot");

    a_requeue_marks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.requeue |=> res_requeued_reg && !run_active_reg)
        else $error("requeue not recorded");

    a_switch_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_switched_reg && out_idle_reg))
        else $error("word both switched and idle");

endmodule

// ----- rtl/core/priority_run_queue_scheduler.sv -----
// ----------------------------------------------------------------------------
// priority_run_queue_scheduler: bitmap priority thread scheduler
// FIFO run queue per priority level, pending bitmap, running slot and an
// APB-style enable register.
// ----------------------------------------------------------------------------
// One request word is taken at a time and answered by one response word.
// A block, an ignored kind, a suspended or out-of-range wake, or a select
// while disabled goes straight to the response. A select with an active
// running thread compares its level with the first pending level and keeps
// it or requeues it; a select with no active running thread goes idle if
// nothing is pending and else pops the head of the first pending level. A
// queued wake appends to its level's list; a requeue appends the running
// thread and then pops. A finished response waits for the output register
// to free. The steps are set by the registered reads of the level, head,
// tail and link tables, and by the single write port of the link table,
// which an append to a pending level uses twice. A new request is taken
// while a finished response waits in the output register. Register 0 (byte
// address 0) is scheduler_enabled, reset 1.
module priority_run_queue_scheduler #(
    parameter int MAX_THREADS     = 64,
    parameter int PRIORITY_LEVELS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    prq_req_if.sink                            req,
    prq_rsp_if.source                          rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [prq_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [prq_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [prq_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import prq_pkg::*;

    logic        enabled_reg;
    logic        cfg_wr;
    prq_cmd_t    cmd;
    prq_status_t status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ENABLED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            enabled_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_ENABLED) ? {{(CFG_DATA_W-1){1'b0}}, enabled_reg}
                                              : '0;

    prq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    prq_dp #(
        .MAX_THREADS     (MAX_THREADS),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .kind         (req.kind),
        .thread_id    (req.thread_id),
        .priority_req (req.priority_req),
        .suspended    (req.suspended),
        .force_switch (req.force_switch),
        .enabled      (enabled_reg),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .out_switched (rsp.switched),
        .out_selected (rsp.selected_thread),
        .out_idle     (rsp.idle),
        .out_requeued (rsp.requeued),
        .out_queued   (rsp.queued)
    );

endmodule
